[rtl/smpm_pkg.sv]
// ----------------------------------------------------------------------------
// smpm_pkg
// Shared types, constants and lookup tables of the stereo mixer core.
// ----------------------------------------------------------------------------
package smpm_pkg;

    localparam int MAX_STRIPS      = 8;
    localparam int STRIP_W         = 3;
    localparam int GAIN_W          = 20;   // Q4.16 gain, max +24 dB
    localparam int COS_W           = 17;   // Q16 cosine, max 1.0
    localparam int LEVEL_ENTRIES   = 121;  // -96 dB .. +24 dB
    localparam int GAIN_IDX_W      = 7;
    localparam int PAN_W           = 8;
    localparam int COS_ENTRIES     = 255;
    localparam int COS_LAST        = 254;
    localparam int ACC_W           = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int DEF_NUM_STRIPS  = 8;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int CFG_ADDR_W      = 6;
    localparam int CFG_DATA_W      = 64;
    localparam logic [7:0] DIM_RESET = 8'hEC;  // -20 dB

    typedef enum logic [2:0] {
        REG_VOLUME     = 3'd0,
        REG_PAN        = 3'd1,
        REG_MUTE       = 3'd2,
        REG_SOLO       = 3'd3,
        REG_MONO_SRC   = 3'd4,
        REG_SOLO_FRONT = 3'd5,
        REG_DIM        = 3'd6,
        REG_MONO_OUT   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [63:0]        volume_levels;
        logic [63:0]        pan_positions;
        logic [7:0]         mute_mask;
        logic [7:0]         solo_mask;
        logic [7:0]         mono_source_mask;
        logic               solo_in_front;
        logic signed [7:0]  solo_dim_db;
        logic               mono_output;
    } cfg_t;

    typedef struct packed {
        logic                  in_range;
        logic                  active;
        logic                  dim;
        logic                  mono_out;
        logic                  last_strip;
        logic                  last_frame;
        logic [STRIP_W-1:0]    strip;
        logic [GAIN_IDX_W-1:0] gain_idx;
        logic [GAIN_IDX_W-1:0] dim_idx;
        logic [PAN_W-1:0]      pan_k;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef logic [GAIN_W-1:0] gain_tab_t [LEVEL_ENTRIES];
    typedef logic [COS_W-1:0]  cos_tab_t  [COS_ENTRIES];

    // gain = round(dec[r] * 10^q / 1600000) with level + 100 = 20q + r
    function automatic gain_tab_t build_gain_tab();
        gain_tab_t         tab;
        longint unsigned   dec [20];
        longint unsigned   p10;
        int                idx;
        dec = '{64'd1048576, 64'd1176521, 64'd1320079, 64'd1481153, 64'd1661881,
                64'd1864661, 64'd2092184, 64'd2347469, 64'd2633903, 64'd2955289,
                64'd3315889, 64'd3720488, 64'd4174457, 64'd4683817, 64'd5255329,
                64'd5896576, 64'd6616067, 64'd7423350, 64'd8329135, 64'd9345443};
        tab[0] = '0;
        for (int i = 1; i < LEVEL_ENTRIES; i++)
        begin
            idx = i + 4;
            p10 = 1;
            for (int j = 0; j < idx / 20; j++)
            begin
                p10 = p10 * 10;
            end
            tab[i] = GAIN_W'((dec[idx % 20] * p10 + 64'd800000) / 64'd1600000);
        end
        return tab;
    endfunction

    // Taylor step divisors, innermost term first
    function automatic longint unsigned cos_step_div(longint unsigned v, int i);
        case (i)
            0:       return v / 64'd132;
            1:       return v / 64'd90;
            2:       return v / 64'd56;
            3:       return v / 64'd30;
            4:       return v / 64'd12;
            default: return v >> 1;
        endcase
    endfunction

    // cos(k*pi/508), Q30 series through x^12, rounded to Q16
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   acc;
        longint unsigned   t;
        for (int k = 0; k < COS_ENTRIES; k++)
        begin
            x   = (longint'(k) * 64'd3373259426 + 64'd254) / 64'd508;
            x2  = (x * x) >> 30;
            acc = 64'd1 << 30;
            for (int i = 0; i < 6; i++)
            begin
                t   = cos_step_div((x2 * acc) >> 30, i);
                acc = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
            end
            tab[k] = COS_W'((acc + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam gain_tab_t GAIN_TAB = build_gain_tab();
    localparam cos_tab_t  COS_TAB  = build_cos_tab();

endpackage

[rtl/stereo_mixer_pan_solo_meter_core.sv]
// ----------------------------------------------------------------------------
// stereo_mixer_pan_solo_meter_core
// Eight-strip stereo mixer with constant-power pan, mute, solo and meters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one strip's sample pair per
//   transaction. Every input transaction yields exactly one output
//   transaction (out_valid/out_ready) with the strip's running peaks, the
//   master peaks and, on the strip flagged last_strip, the saturated mix.
//   Settings are written over the APB port while no transaction is in flight.
// Timing:
//   The back-end sequencer handles one strip at a time in steps (lookup,
//   dim gain, pan gain, multiply, accumulate/commit) and takes the next
//   queued strip when it commits the last one. A two-entry queue sits
//   between the input classifier and the sequencer.
// Reset and stall:
//   rst_n clears settings to their defaults, the frame accumulators and all
//   peaks. While out_ready is low the result is held; the sequencer finishes
//   the next strip and waits, and the queue keeps taking input until full.
// ----------------------------------------------------------------------------
module stereo_mixer_pan_solo_meter_core #(
    parameter int NUM_STRIPS  = smpm_pkg::DEF_NUM_STRIPS,
    parameter int SAMPLE_BITS = smpm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smpm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [smpm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [smpm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [smpm_pkg::STRIP_W-1:0]        strip,
    input  logic [SAMPLE_BITS-1:0]              sample_left,
    input  logic [SAMPLE_BITS-1:0]              sample_right,
    input  logic                                last_strip,
    input  logic                                last_frame,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [SAMPLE_BITS-2:0]              strip_peak_left,
    output logic [SAMPLE_BITS-2:0]              strip_peak_right,
    output logic                                mix_valid,
    output logic [SAMPLE_BITS-1:0]              mix_left,
    output logic [SAMPLE_BITS-1:0]              mix_right,
    output logic [SAMPLE_BITS-2:0]              master_peak_left,
    output logic [SAMPLE_BITS-2:0]              master_peak_right
);

    localparam int ITEM_W  = $bits(smpm_pkg::item_t);
    localparam int ENTRY_W = ITEM_W + 2 * SAMPLE_BITS;

    smpm_pkg::cfg_t          cfg_reg;
    smpm_pkg::reg_idx_t      wr_idx;
    smpm_pkg::queue_status_t qstat;
    smpm_pkg::item_t         f_item;
    smpm_pkg::item_t         head_item;
    logic [SAMPLE_BITS-1:0]  f_left;
    logic [SAMPLE_BITS-1:0]  f_right;
    logic [SAMPLE_BITS-1:0]  head_left;
    logic [SAMPLE_BITS-1:0]  head_right;
    logic [ENTRY_W-1:0]      q_rdata;
    logic                    push;
    logic                    pop;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign wr_idx    = smpm_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume_levels    <= '0;
            cfg_reg.pan_positions    <= '0;
            cfg_reg.mute_mask        <= '0;
            cfg_reg.solo_mask        <= '0;
            cfg_reg.mono_source_mask <= '0;
            cfg_reg.solo_in_front    <= 1'b0;
            cfg_reg.solo_dim_db      <= smpm_pkg::DIM_RESET;
            cfg_reg.mono_output      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (wr_idx)
                smpm_pkg::REG_VOLUME:     cfg_reg.volume_levels    <= pwdata;
                smpm_pkg::REG_PAN:        cfg_reg.pan_positions    <= pwdata;
                smpm_pkg::REG_MUTE:       cfg_reg.mute_mask        <= pwdata[7:0];
                smpm_pkg::REG_SOLO:       cfg_reg.solo_mask        <= pwdata[7:0];
                smpm_pkg::REG_MONO_SRC:   cfg_reg.mono_source_mask <= pwdata[7:0];
                smpm_pkg::REG_SOLO_FRONT: cfg_reg.solo_in_front    <= pwdata[0];
                smpm_pkg::REG_DIM:        cfg_reg.solo_dim_db      <= pwdata[7:0];
                smpm_pkg::REG_MONO_OUT:   cfg_reg.mono_output      <= pwdata[0];
                default:                  cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (smpm_pkg::reg_idx_t'(paddr[5:3]))
            smpm_pkg::REG_VOLUME:     prdata = cfg_reg.volume_levels;
            smpm_pkg::REG_PAN:        prdata = cfg_reg.pan_positions;
            smpm_pkg::REG_MUTE:       prdata = 64'(cfg_reg.mute_mask);
            smpm_pkg::REG_SOLO:       prdata = 64'(cfg_reg.solo_mask);
            smpm_pkg::REG_MONO_SRC:   prdata = 64'(cfg_reg.mono_source_mask);
            smpm_pkg::REG_SOLO_FRONT: prdata = 64'(cfg_reg.solo_in_front);
            smpm_pkg::REG_DIM:        prdata = 64'(cfg_reg.solo_dim_db);
            smpm_pkg::REG_MONO_OUT:   prdata = 64'(cfg_reg.mono_output);
            default:                  prdata = '0;
        endcase
    end

    smpm_front #(
        .NUM_STRIPS  (NUM_STRIPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .strip        (strip),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .last_strip   (last_strip),
        .last_frame   (last_frame),
        .qstat        (qstat),
        .push         (push),
        .item         (f_item),
        .item_left    (f_left),
        .item_right   (f_right)
    );

    smpm_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (smpm_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  ({f_item, f_left, f_right}),
        .pop    (pop),
        .rdata  (q_rdata),
        .status (qstat)
    );

    assign head_item  = smpm_pkg::item_t'(q_rdata[ENTRY_W-1 -: ITEM_W]);
    assign head_left  = q_rdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign head_right = q_rdata[SAMPLE_BITS-1:0];

    smpm_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head_item),
        .head_left         (head_left),
        .head_right        (head_right),
        .head_avail        (!qstat.empty),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .strip_peak_left   (strip_peak_left),
        .strip_peak_right  (strip_peak_right),
        .mix_valid         (mix_valid),
        .mix_left          (mix_left),
        .mix_right         (mix_right),
        .master_peak_left  (master_peak_left),
        .master_peak_right (master_peak_right)
    );

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_mix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !mix_valid) |-> (mix_left == '0 && mix_right == '0))
        else $error("mix fields set without a completed frame");

endmodule

[rtl/smpm_fifo.sv]
// ----------------------------------------------------------------------------
// smpm_fifo
// Short queue between the classifying front end and the processing back end.
// ----------------------------------------------------------------------------
module smpm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = smpm_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        wdata,
    input  logic                    pop,
    output logic [WIDTH-1:0]        rdata,
    output smpm_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (pop)
            begin
                rptr_reg <= bump(rptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign rdata        = mem[rptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

[rtl/smpm_front.sv]
// ----------------------------------------------------------------------------
// smpm_front
// Accepts strip transactions and classifies them against mute, solo, level
// and pan settings before they are queued.
// ----------------------------------------------------------------------------
module smpm_front #(
    parameter int NUM_STRIPS  = smpm_pkg::DEF_NUM_STRIPS,
    parameter int SAMPLE_BITS = smpm_pkg::DEF_SAMPLE_BITS
) (
    input  smpm_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [smpm_pkg::STRIP_W-1:0]  strip,
    input  logic [SAMPLE_BITS-1:0]        sample_left,
    input  logic [SAMPLE_BITS-1:0]        sample_right,
    input  logic                          last_strip,
    input  logic                          last_frame,
    input  smpm_pkg::queue_status_t       qstat,
    output logic                          push,
    output smpm_pkg::item_t               item,
    output logic [SAMPLE_BITS-1:0]        item_left,
    output logic [SAMPLE_BITS-1:0]        item_right
);

    localparam logic [7:0] STRIP_MASK = 8'((1 << NUM_STRIPS) - 1);

    logic [7:0]        smask;
    logic              any_solo;
    logic              soloed;
    logic signed [7:0] level;
    logic signed [7:0] pan;
    logic signed [8:0] level_ofs;
    logic signed [8:0] dim_ofs;

    assign in_ready = !qstat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        smask    = cfg.solo_mask & STRIP_MASK;
        any_solo = |smask;
        soloed   = smask[strip];
        level    = cfg.volume_levels[strip*8 +: 8];
        pan      = cfg.pan_positions[strip*8 +: 8];

        item            = '0;
        item.in_range   = ({1'b0, strip} < 4'(NUM_STRIPS));
        item.active     = item.in_range && !cfg.mute_mask[strip]
                          && !(any_solo && !soloed && !cfg.solo_in_front);
        item.dim        = any_solo && !soloed;
        item.mono_out   = cfg.mono_output;
        item.last_strip = last_strip;
        item.last_frame = last_frame;
        item.strip      = strip;

        // table entry 0 is silence (-96 dB and below), top entry is +24 dB
        level_ofs = 9'(level) + 9'sd96;
        if (level <= -8'sd96)
        begin
            item.gain_idx = '0;
        end
        else if (level > 8'sd24)
        begin
            item.gain_idx = 7'(smpm_pkg::LEVEL_ENTRIES - 1);
        end
        else
        begin
            item.gain_idx = level_ofs[6:0];
        end

        dim_ofs = 9'(cfg.solo_dim_db) + 9'sd96;
        if (cfg.solo_dim_db > 8'sd0)
        begin
            item.dim_idx = 7'd96;
        end
        else if (cfg.solo_dim_db < -8'sd96)
        begin
            item.dim_idx = '0;
        end
        else
        begin
            item.dim_idx = dim_ofs[6:0];
        end

        // hard-left code -128 folds onto -127
        if (pan == -8'sd128)
        begin
            item.pan_k = '0;
        end
        else
        begin
            item.pan_k = 8'(pan + 8'sd127);
        end
    end

    assign item_left  = sample_left;
    assign item_right = cfg.mono_source_mask[strip] ? sample_left : sample_right;

endmodule

[rtl/smpm_back.sv]
// ----------------------------------------------------------------------------
// smpm_back
// Sequencer that scales one queued strip, accumulates the frame, tracks
// peaks and holds the result register.
// ----------------------------------------------------------------------------
module smpm_back #(
    parameter int SAMPLE_BITS = smpm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  smpm_pkg::item_t         head,
    input  logic [SAMPLE_BITS-1:0]  head_left,
    input  logic [SAMPLE_BITS-1:0]  head_right,
    input  logic                    head_avail,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_BITS-2:0]  strip_peak_left,
    output logic [SAMPLE_BITS-2:0]  strip_peak_right,
    output logic                    mix_valid,
    output logic [SAMPLE_BITS-1:0]  mix_left,
    output logic [SAMPLE_BITS-1:0]  mix_right,
    output logic [SAMPLE_BITS-2:0]  master_peak_left,
    output logic [SAMPLE_BITS-2:0]  master_peak_right
);

    localparam int SB     = SAMPLE_BITS;
    localparam int GW     = smpm_pkg::GAIN_W;
    localparam int CW     = smpm_pkg::COS_W;
    localparam int AW     = smpm_pkg::ACC_W;
    localparam int MAG_W  = SB + 1;
    localparam int PROD_W = MAG_W + GW;
    localparam int TERM_W = SB + 5;
    localparam int SUM_W  = ((TERM_W + 1 > AW) ? TERM_W + 1 : AW) + 1;
    localparam int PK_W   = SB - 1;

    localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);
    localparam logic signed [AW-1:0]    SMP_HI = AW'((longint'(1) << (SB - 1)) - 1);
    localparam logic signed [AW-1:0]    SMP_LO = -SMP_HI - AW'(1);

    typedef enum logic [2:0] {S_IDLE, S_GAIN, S_PAN, S_MUL, S_FIN} state_t;

    state_t                state_reg;
    smpm_pkg::item_t       item_reg;
    logic [SB-1:0]         sl_reg;
    logic [SB-1:0]         sr_reg;
    logic [GW-1:0]         g_reg;
    logic [GW-1:0]         dimg_reg;
    logic [CW-1:0]         cosl_reg;
    logic [CW-1:0]         cosr_reg;
    logic [MAG_W-1:0]      magl_reg;
    logic [MAG_W-1:0]      magr_reg;
    logic                  negl_reg;
    logic                  negr_reg;
    logic [GW-1:0]         gl_reg;
    logic [GW-1:0]         gr_reg;
    logic [PROD_W-1:0]     prodl_reg;
    logic [PROD_W-1:0]     prodr_reg;
    logic signed [AW-1:0]  accl_reg;
    logic signed [AW-1:0]  accr_reg;
    logic [PK_W-1:0]       spk_l_reg [smpm_pkg::MAX_STRIPS];
    logic [PK_W-1:0]       spk_r_reg [smpm_pkg::MAX_STRIPS];
    logic [PK_W-1:0]       mpk_l_reg;
    logic [PK_W-1:0]       mpk_r_reg;
    logic                  out_valid_reg;

    logic                  commit;
    logic [GW-1:0]         g_next;
    logic [MAG_W-1:0]      magl_next;
    logic [MAG_W-1:0]      magr_next;
    logic                  negl_next;
    logic                  negr_next;
    logic [GW-1:0]         gl_next;
    logic [GW-1:0]         gr_next;
    logic signed [MAG_W-1:0] mono_sum;
    logic [PROD_W:0]       rndl;
    logic [PROD_W:0]       rndr;
    logic [TERM_W-1:0]     tmagl;
    logic [TERM_W-1:0]     tmagr;
    logic signed [TERM_W:0] terml;
    logic signed [TERM_W:0] termr;
    logic signed [SUM_W-1:0] suml;
    logic signed [SUM_W-1:0] sumr;
    logic signed [AW-1:0]  accl_next;
    logic signed [AW-1:0]  accr_next;
    logic [SB-1:0]         ml_next;
    logic [SB-1:0]         mr_next;
    logic [PK_W-1:0]       spl_next;
    logic [PK_W-1:0]       spr_next;
    logic [PK_W-1:0]       mpl_next;
    logic [PK_W-1:0]       mpr_next;

    function automatic logic [MAG_W-1:0] mag_of(logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
    endfunction

    function automatic logic [GW-1:0] gmul_cos(logic [CW-1:0] c, logic [GW-1:0] g);
        logic [CW+GW:0] p;
        p = (CW+GW+1)'(c) * (CW+GW+1)'(g) + (CW+GW+1)'(32768);
        return p[GW+15:16];
    endfunction

    function automatic logic [PK_W-1:0] clamp_term(logic [TERM_W-1:0] m);
        return (|m[TERM_W-1:PK_W]) ? '1 : m[PK_W-1:0];
    endfunction

    function automatic logic [PK_W-1:0] abs_smp(logic [SB-1:0] v);
        logic [SB-1:0] a;
        a = v[SB-1] ? (~v + SB'(1)) : v;
        return a[SB-1] ? '1 : a[PK_W-1:0];
    endfunction

    function automatic logic signed [AW-1:0] sat_acc(logic signed [SUM_W-1:0] s);
        if (s > ACC_HI)
        begin
            return AW'(ACC_HI);
        end
        else if (s < ACC_LO)
        begin
            return AW'(ACC_LO);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [SB-1:0] sat_smp(logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        r = (a > SMP_HI) ? SMP_HI : ((a < SMP_LO) ? SMP_LO : a);
        return r[SB-1:0];
    endfunction

    assign commit = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign pop    = head_avail && ((state_reg == S_IDLE) || commit);

    always_comb
    begin
        logic [2*GW:0] gd;
        gd     = (2*GW+1)'(g_reg) * (2*GW+1)'(dimg_reg) + (2*GW+1)'(32768);
        g_next = item_reg.dim ? gd[GW+15:16] : g_reg;

        mono_sum = MAG_W'($signed(sl_reg)) + MAG_W'($signed(sr_reg));
        if (item_reg.mono_out)
        begin
            magl_next = mag_of(mono_sum);
            negl_next = mono_sum[MAG_W-1];
            gl_next   = g_reg;
        end
        else
        begin
            magl_next = mag_of(MAG_W'($signed(sl_reg)));
            negl_next = sl_reg[SB-1];
            gl_next   = gmul_cos(cosl_reg, g_reg);
        end
        magr_next = item_reg.mono_out ? magl_next : mag_of(MAG_W'($signed(sr_reg)));
        negr_next = item_reg.mono_out ? negl_next : sr_reg[SB-1];
        gr_next   = item_reg.mono_out ? gl_next : gmul_cos(cosr_reg, g_reg);
    end

    always_comb
    begin
        // mono output halves the L+R sum: one more bit of shift
        if (item_reg.mono_out)
        begin
            rndl  = {1'b0, prodl_reg} + (PROD_W+1)'(65536);
            rndr  = {1'b0, prodr_reg} + (PROD_W+1)'(65536);
            tmagl = TERM_W'(rndl >> 17);
            tmagr = TERM_W'(rndr >> 17);
        end
        else
        begin
            rndl  = {1'b0, prodl_reg} + (PROD_W+1)'(32768);
            rndr  = {1'b0, prodr_reg} + (PROD_W+1)'(32768);
            tmagl = TERM_W'(rndl >> 16);
            tmagr = TERM_W'(rndr >> 16);
        end
        if (!item_reg.active)
        begin
            tmagl = '0;
            tmagr = '0;
        end
        terml = negl_reg ? -$signed({1'b0, tmagl}) : $signed({1'b0, tmagl});
        termr = negr_reg ? -$signed({1'b0, tmagr}) : $signed({1'b0, tmagr});
        suml  = SUM_W'(accl_reg) + SUM_W'(terml);
        sumr  = SUM_W'(accr_reg) + SUM_W'(termr);
        accl_next = sat_acc(suml);
        accr_next = sat_acc(sumr);

        spl_next = spk_l_reg[item_reg.strip];
        spr_next = spk_r_reg[item_reg.strip];
        if (clamp_term(tmagl) > spl_next)
        begin
            spl_next = clamp_term(tmagl);
        end
        if (clamp_term(tmagr) > spr_next)
        begin
            spr_next = clamp_term(tmagr);
        end

        ml_next  = sat_smp(accl_next);
        mr_next  = item_reg.mono_out ? ml_next : sat_smp(accr_next);
        mpl_next = mpk_l_reg;
        mpr_next = mpk_r_reg;
        if (item_reg.last_strip)
        begin
            if (abs_smp(ml_next) > mpl_next)
            begin
                mpl_next = abs_smp(ml_next);
            end
            if (abs_smp(mr_next) > mpr_next)
            begin
                mpr_next = abs_smp(mr_next);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
            sl_reg   <= head_left;
            sr_reg   <= head_right;
            g_reg    <= smpm_pkg::GAIN_TAB[head.gain_idx];
            dimg_reg <= smpm_pkg::GAIN_TAB[head.dim_idx];
            cosl_reg <= smpm_pkg::COS_TAB[head.pan_k];
            cosr_reg <= smpm_pkg::COS_TAB[8'(smpm_pkg::COS_LAST) - head.pan_k];
        end
        else if (state_reg == S_GAIN)
        begin
            g_reg <= g_next;
        end
        if (state_reg == S_PAN)
        begin
            magl_reg <= magl_next;
            magr_reg <= magr_next;
            negl_reg <= negl_next;
            negr_reg <= negr_next;
            gl_reg   <= gl_next;
            gr_reg   <= gr_next;
        end
        if (state_reg == S_MUL)
        begin
            prodl_reg <= magl_reg * gl_reg;
            prodr_reg <= magr_reg * gr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            accl_reg          <= '0;
            accr_reg          <= '0;
            mpk_l_reg         <= '0;
            mpk_r_reg         <= '0;
            for (int i = 0; i < smpm_pkg::MAX_STRIPS; i++)
            begin
                spk_l_reg[i] <= '0;
                spk_r_reg[i] <= '0;
            end
            strip_peak_left   <= '0;
            strip_peak_right  <= '0;
            mix_valid         <= 1'b0;
            mix_left          <= '0;
            mix_right         <= '0;
            master_peak_left  <= '0;
            master_peak_right <= '0;
        end
        else
        begin
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    state_reg <= S_PAN;
                end
                S_PAN:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (commit)
                    begin
                        state_reg <= pop ? S_GAIN : S_IDLE;
                        accl_reg  <= item_reg.last_strip ? '0 : accl_next;
                        accr_reg  <= item_reg.last_strip ? '0 : accr_next;
                        strip_peak_left   <= item_reg.in_range ? spl_next : '0;
                        strip_peak_right  <= !item_reg.in_range ? '0 :
                                             (item_reg.mono_out ? spl_next : spr_next);
                        mix_valid         <= item_reg.last_strip;
                        mix_left          <= item_reg.last_strip ? ml_next : '0;
                        mix_right         <= item_reg.last_strip ? mr_next : '0;
                        master_peak_left  <= mpl_next;
                        master_peak_right <= item_reg.mono_out ? mpl_next : mpr_next;
                        // end of metering block: peaks restart after this result
                        if (item_reg.last_strip && item_reg.last_frame)
                        begin
                            mpk_l_reg <= '0;
                            mpk_r_reg <= '0;
                            for (int i = 0; i < smpm_pkg::MAX_STRIPS; i++)
                            begin
                                spk_l_reg[i] <= '0;
                                spk_r_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            spk_l_reg[item_reg.strip] <= spl_next;
                            spk_r_reg[item_reg.strip] <= spr_next;
                            mpk_l_reg <= mpl_next;
                            mpk_r_reg <= mpr_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule
